>>> sv/wibt_pkg.sv
// wibt_pkg: shared types and constants for the wildcard IPv4 ban table.
// No dependencies; imported by wibt_entry_eval, wildcard_ip_ban_table and wibt_checker.
`timescale 1ns / 1ps

package wibt_pkg;

    // Action codes on s_action
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Ban status codes on m_ban_status
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_PERM = 2'd1;
    localparam logic [1:0] ST_TEMP = 2'd2;

    // Pattern octet that matches any address octet
    localparam logic [7:0] WILD_OCTET = 8'hFF;

    // Stored entry body: pattern above expiry
    typedef struct packed {
        logic [31:0] pattern;
        logic [31:0] expiry;
    } entry_t;

    // Verdict on one table entry during a scan
    typedef struct packed {
        logic       stop;       // scan ends at this entry
        logic       clr_valid;  // free this entry
        logic       set_valid;  // claim this entry (add)
        logic [1:0] status;
        logic       freed;
    } eval_t;

    // Control sequencer states
    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

>>> sv/wibt_ram.sv
// wibt_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wibt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/wibt_entry_eval.sv
// wibt_entry_eval: judges one table entry against the current action.
// Depends on wibt_pkg.
`timescale 1ns / 1ps

module wibt_entry_eval import wibt_pkg::*; (
    input  logic [1:0]  action,
    input  logic [31:0] key_addr,
    input  logic [31:0] now_time,
    input  logic        ent_valid,
    input  entry_t      ent,
    output eval_t       verdict
);

    logic [3:0] octet_ok;
    logic       wild_hit;
    logic       exact_hit;

    // Per-octet wildcard compare
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            octet_ok[k] = (ent.pattern[8*k +: 8] == WILD_OCTET) ||
                          (ent.pattern[8*k +: 8] == key_addr[8*k +: 8]);
        end
    end

    assign wild_hit  = ent_valid && (&octet_ok);
    assign exact_hit = ent_valid && (ent.pattern == key_addr);

    always_comb begin
        verdict = '0;
        case (action)
            ACT_LOOKUP: begin
                if (wild_hit) begin
                    verdict.stop = 1'b1;
                    if (ent.expiry == 32'd0) begin
                        verdict.status = ST_PERM;
                    end else if (ent.expiry > now_time) begin
                        verdict.status = ST_TEMP;
                    end else begin
                        verdict.clr_valid = 1'b1;
                        verdict.freed     = 1'b1;
                    end
                end
            end
            ACT_ADD: begin
                if (!ent_valid) begin
                    verdict.stop      = 1'b1;
                    verdict.set_valid = 1'b1;
                end
            end
            ACT_REMOVE: begin
                verdict.clr_valid = exact_hit;
            end
            default: begin
                verdict = '0;
            end
        endcase
    end

endmodule

>>> sv/wildcard_ip_ban_table.sv
// wildcard_ip_ban_table: top level of the wildcard IPv4 ban table.
// Depends on wibt_pkg, wibt_ram and wibt_entry_eval.
`timescale 1ns / 1ps

// One item is worked at a time. The table sits in two RAMs (valid bits and
// pattern/expiry), read one slot per cycle through a registered read port, so
// a lookup or add scans slots in order and ends at the deciding slot or at the
// last slot, while a remove scans every slot and frees each exact match.
// Clear sweeps every valid bit. After reset a clearing pass over every slot
// runs with s_ready low. A new item is taken as soon as the result is
// handed to the output register, even while that result waits for m_ready.
module wildcard_ip_ban_table import wibt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_ip_addr,
    input  logic [31:0] s_expire_time,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_ban_status,
    output logic        m_expired_removed,
    output logic        m_op_ok
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] END_IDX   = CW'(TABLE_DEPTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;

    // Latched item
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [31:0] exp_reg;
    logic [31:0] now_reg;

    // Result waiting for the output register
    logic [1:0] res_status_reg, res_status_next;
    logic       res_freed_reg, res_freed_next;
    logic       res_ok_reg, res_ok_next;

    logic       m_valid_reg;
    logic [1:0] m_status_reg;
    logic       m_freed_reg;
    logic       m_ok_reg;

    logic          issuing;
    logic          scan_end;
    logic          sweep_end;
    logic          out_load;
    logic          accept;
    logic [AW-1:0] rd_addr;

    logic          v_we;
    logic [AW-1:0] v_waddr;
    logic          v_wdata;
    logic          v_rdata;
    logic          d_we;
    entry_t        d_wdata;
    entry_t        d_rdata;
    eval_t         verdict;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign rd_addr   = idx_reg[AW-1:0];
    assign issuing   = (state_reg == S_SCAN) && (idx_reg != END_IDX);
    assign scan_end  = (state_reg == S_SCAN) && chk_vld_reg &&
                       (verdict.stop || (chk_addr_reg == LAST_ADDR));
    assign sweep_end = (rd_addr == LAST_ADDR);
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Table memories
    wibt_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
        .clk   (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    wibt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_entry_ram (
        .clk   (aclk),
        .we    (d_we),
        .waddr (chk_addr_reg),
        .wdata (d_wdata),
        .raddr (rd_addr),
        .rdata (d_rdata)
    );

    wibt_entry_eval u_eval (
        .action    (op_reg),
        .key_addr  (addr_reg),
        .now_time  (now_reg),
        .ent_valid (v_rdata),
        .ent       (d_rdata),
        .verdict   (verdict)
    );

    // Write-back: sweeps clear valid bits, scans update the checked slot
    always_comb begin
        v_we    = 1'b0;
        v_waddr = chk_addr_reg;
        v_wdata = 1'b0;
        d_we    = 1'b0;
        d_wdata.pattern = addr_reg;
        d_wdata.expiry  = exp_reg;
        if (state_reg == S_INIT || state_reg == S_CLEAR) begin
            v_we    = 1'b1;
            v_waddr = rd_addr;
        end else if (state_reg == S_SCAN && chk_vld_reg) begin
            v_we    = verdict.clr_valid || verdict.set_valid;
            v_wdata = verdict.set_valid;
            d_we    = verdict.set_valid;
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        res_status_next = res_status_reg;
        res_freed_next  = res_freed_reg;
        res_ok_next     = res_ok_reg;
        case (state_reg)
            S_INIT: begin
                idx_next = idx_reg + 1'b1;
                if (sweep_end) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    res_status_next = ST_NONE;
                    res_freed_next  = 1'b0;
                    res_ok_next     = 1'b1;
                    state_next      = (s_action == ACT_CLEAR) ? S_CLEAR : S_SCAN;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    idx_next      = idx_reg + 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_addr_next = rd_addr;
                end
                if (scan_end) begin
                    chk_vld_next    = 1'b0;
                    res_status_next = verdict.stop ? verdict.status : ST_NONE;
                    res_freed_next  = verdict.stop && verdict.freed;
                    res_ok_next     = (op_reg != ACT_ADD) || verdict.stop;
                    state_next      = S_DONE;
                end
            end
            S_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (sweep_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
                idx_next   = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_freed_reg  <= res_freed_next;
        res_ok_reg     <= res_ok_next;
        if (accept) begin
            op_reg   <= s_action;
            addr_reg <= s_ip_addr;
            exp_reg  <= s_expire_time;
            now_reg  <= s_now_time;
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_freed_reg  <= res_freed_reg;
            m_ok_reg     <= res_ok_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ban_status      = m_status_reg;
    assign m_expired_removed = m_freed_reg;
    assign m_op_ok           = m_ok_reg;

endmodule

>>> sv/wibt_checker.sv
// wibt_checker: port-level assertions for wildcard_ip_ban_table, bound to it.
// Depends on wibt_pkg and on the top level's port list.
`timescale 1ns / 1ps

module wibt_checker import wibt_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_ban_status,
    input logic        m_expired_removed,
    input logic        m_op_ok
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ban_status) &&
        $stable(m_expired_removed) && $stable(m_op_ok))
        else $error("result changed while stalled");

    // Status code stays in range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ban_status == ST_NONE || m_ban_status == ST_PERM ||
                     m_ban_status == ST_TEMP))
        else $error("bad ban status");

    // An expired entry that was freed reports not banned
    a_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_expired_removed |-> m_ban_status == ST_NONE && m_op_ok)
        else $error("freed entry with ban status");

    // Table is swept after reset before any transfer
    a_init: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during reset sweep");

    // One item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer while busy");

endmodule

bind wildcard_ip_ban_table wibt_checker u_wibt_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_ban_status      (m_ban_status),
    .m_expired_removed (m_expired_removed),
    .m_op_ok           (m_op_ok)
);
